[hdl/wspc_pkg.sv]
// Package for the wheel speed PID controller: widths, register indexes,
// sequencer states. No dependencies.
`default_nettype none
package wspc_pkg;
   localparam int CntW   = 16;
   localparam int BattW  = 12;
   localparam int SpdW   = 21;
   localparam int ErrW   = 22;
   localparam int IntW   = 48;
   localparam int PosW   = 40;
   localparam int VoltW  = 17;
   localparam int DutyW  = 16;
   localparam int GainW  = 24;
   localparam int AccW   = 72;
   localparam int AddrW  = 5;

   localparam logic [2:0] RegEnable   = 3'd0;
   localparam logic [2:0] RegKp       = 3'd1;
   localparam logic [2:0] RegKi       = 3'd2;
   localparam logic [2:0] RegKd       = 3'd3;
   localparam logic [2:0] RegSpdScale = 3'd4;
   localparam logic [2:0] RegDstScale = 3'd5;
   localparam logic [2:0] RegMaxSpeed = 3'd6;
   localparam logic [2:0] RegMaxVolt  = 3'd7;

   localparam logic [1:0] DirBrake   = 2'd0;
   localparam logic [1:0] DirForward = 2'd1;
   localparam logic [1:0] DirReverse = 2'd2;

   // Duty constants: numerator multiplier and denominator scale
   localparam logic [30:0] BattNumK   = 31'd1355713939;
   localparam logic [18:0] BattDenK   = 19'd409600;
   localparam logic [30:0] NoBattNumK = 31'd655350;
   localparam logic [30:0] NoBattDen  = 31'd688128;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCALE, ST_SPEED, ST_PID_P, ST_PID_I, ST_PID_D, ST_VOLT,
      ST_DUTY_MUL, ST_DUTY_DIV, ST_DONE
   } state_type;

   typedef struct packed {
      logic              start;
      logic [GainW-1:0]  mcand;
      logic signed [IntW:0] mplier;
   } mul_req_type;
endpackage
`default_nettype wire

[hdl/wspc_if.sv]
// Valid/ready channel interface carrying the request or response payload.
// Depends on nothing.
`default_nettype none
interface wspc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] encoder_count;
   logic [11:0]        battery_reading;
   logic signed [20:0] target_speed;
   logic               clear_position;
   modport source (output valid, encoder_count, battery_reading, target_speed,
                   clear_position, input ready);
   modport sink   (input valid, encoder_count, battery_reading, target_speed,
                   clear_position, output ready);
endinterface

interface wspc_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        duty;
   logic [1:0]         direction;
   logic signed [16:0] drive_voltage;
   logic signed [20:0] measured_speed;
   logic signed [39:0] travelled_distance;
   modport source (output valid, duty, direction, drive_voltage, measured_speed,
                   travelled_distance, input ready);
   modport sink   (input valid, duty, direction, drive_voltage, measured_speed,
                   travelled_distance, output ready);
endinterface
`default_nettype wire

[hdl/wspc_mul.sv]
// Bit-serial signed-by-unsigned multiplier: one multiplicand bit a cycle,
// product held in a register and flagged in the cycle after the last step.
// Depends on wspc_pkg.
`default_nettype none
module wspc_mul (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [wspc_pkg::GainW-1:0]   mcand,
   input  wire logic signed [wspc_pkg::IntW:0] mplier,
   output logic                              done,
   output logic signed [wspc_pkg::AccW:0]    product
);
   import wspc_pkg::*;

   logic [GainW-1:0]   bits_ff, bits_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic signed [AccW:0] acc_ff, acc_in, addend_ff, addend_in;

   // Shift-add: add the shifted multiplier when the low multiplicand bit is set
   always_comb begin
      bits_in = bits_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      acc_in = acc_ff; addend_in = addend_ff;
      done_in = busy_ff && (cnt_ff == 5'(GainW-1));
      if (start) begin
         bits_in = mcand; cnt_in = 5'd0; busy_in = 1'b1;
         acc_in = '0; addend_in = (AccW+1)'(mplier);
      end else if (busy_ff) begin
         if (bits_ff[0]) acc_in = acc_ff + addend_ff;
         addend_in = addend_ff <<< 1;
         bits_in = bits_ff >> 1;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(GainW-1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
      bits_ff <= bits_in;
      acc_ff <= acc_in;
      addend_ff <= addend_in;
   end

   assign done = done_ff;
   assign product = acc_ff;

   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == 5'd0 || cnt_ff == 5'(GainW))
      else $error("multiplier counter out of step");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |-> !busy_ff) else $error("done while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done |=> !done) else $error("done not single");
endmodule
`default_nettype wire

[hdl/wspc_div.sv]
// Restoring radix-2 divider, one quotient bit a cycle, 64-bit dividend.
// Depends on wspc_pkg.
`default_nettype none
module wspc_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [30:0] divisor,
   output logic             done,
   output logic [63:0]      quotient
);
   import wspc_pkg::*;

   logic [63:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [30:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [31:0] trial;

   // Shift one dividend bit into the remainder and try a subtract
   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; dvs_in = dvs_ff;
      cnt_in = cnt_ff; busy_in = busy_ff;
      trial = {rem_ff[30:0], quo_ff[63]};
      if (start) begin
         quo_in = dividend; rem_in = '0; dvs_in = divisor;
         cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done = busy_ff && !busy_in && !start;
   assign quotient = quo_in;

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff && dvs_ff != '0 |-> rem_ff < {1'b0, dvs_ff})
      else $error("remainder exceeds divisor");
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> busy_ff) else $error("done without busy");
   a_idle_cnt: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> cnt_ff == 7'd64) else $error("divider ended early");
endmodule
`default_nettype wire

[hdl/wheel_speed_pid_controller_unit.sv]
// Wheel speed PID controller, top level: register file, sequencer, duty path.
// Depends on wspc_pkg, wspc_if, wspc_mul and wspc_div.
//
// A tick steps through the sequencer states from the accepting edge to the loaded
// result; with the loop disabled the P, I and D products and the voltage clamp are
// skipped. Every product (speed, distance, P, I, D and the duty numerator) runs
// through one shared bit-serial multiplier at one gain bit a cycle, the product
// flagged in the cycle after the last step; the sequencer clamps the voltage, then
// launches the duty product, and the battery division runs at one quotient bit a
// cycle. The block works on one word at a time; the next request word is
// accepted only in the idle state, once the previous result word has been taken
// or is taken in the same cycle.
`default_nettype none
module wheel_speed_pid_controller_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   wspc_req_if.sink         req,
   wspc_rsp_if.source       rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [wspc_pkg::AddrW-1:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import wspc_pkg::*;

   // Configuration registers
   logic        en_ff;
   logic [GainW-1:0] kp_ff, ki_ff, kd_ff, sscale_ff, dscale_ff;
   logic [19:0] maxspd_ff;
   logic [15:0] maxv_ff;
   logic        wr;
   logic [2:0]  ridx;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign ridx = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b0; kp_ff <= '0; ki_ff <= '0; kd_ff <= '0;
         sscale_ff <= '0; dscale_ff <= '0; maxspd_ff <= '1; maxv_ff <= '1;
      end else if (wr) begin
         unique case (ridx)
            RegEnable:   en_ff <= csr_pwdata[0];
            RegKp:       kp_ff <= csr_pwdata[GainW-1:0];
            RegKi:       ki_ff <= csr_pwdata[GainW-1:0];
            RegKd:       kd_ff <= csr_pwdata[GainW-1:0];
            RegSpdScale: sscale_ff <= csr_pwdata[GainW-1:0];
            RegDstScale: dscale_ff <= csr_pwdata[GainW-1:0];
            RegMaxSpeed: maxspd_ff <= csr_pwdata[19:0];
            RegMaxVolt:  maxv_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Register readback
   always_comb begin
      csr_prdata = '0;
      unique case (ridx)
         RegEnable:   csr_prdata = 32'(en_ff);
         RegKp:       csr_prdata = 32'(kp_ff);
         RegKi:       csr_prdata = 32'(ki_ff);
         RegKd:       csr_prdata = 32'(kd_ff);
         RegSpdScale: csr_prdata = 32'(sscale_ff);
         RegDstScale: csr_prdata = 32'(dscale_ff);
         RegMaxSpeed: csr_prdata = 32'(maxspd_ff);
         RegMaxVolt:  csr_prdata = 32'(maxv_ff);
         default:     csr_prdata = '0;
      endcase
   end

   // Tick state and working registers
   state_type state_ff, state_in;
   logic signed [CntW-1:0] cnt_ff;
   logic [BattW-1:0]       batt_ff;
   logic signed [SpdW-1:0] tgt_ff;
   logic                   clr_ff;
   logic signed [SpdW-1:0] speed_ff;
   logic signed [IntW-1:0] integ_ff;
   logic signed [ErrW-1:0] perr_ff;
   logic signed [ErrW:0]   deriv_ff;
   logic [PosW-1:0]        pos_ff;
   logic signed [VoltW-1:0] hold_ff;
   logic signed [AccW+1:0] acc_ff;
   logic                   neg_ff;
   logic [63:0]            mag_ff;
   logic                   start_div_ff;

   // Output register
   logic                   ovalid_ff;
   logic [DutyW-1:0]       duty_ff;
   logic [1:0]             dir_ff;
   logic signed [VoltW-1:0] ovolt_ff;
   logic signed [SpdW-1:0] ospd_ff;
   logic [PosW-1:0]        opos_ff;

   // Shared multiplier
   mul_req_type mreq;
   logic mdone;
   logic signed [AccW:0] mprod;
   wspc_mul u_mul (.clock, .reset, .start(mreq.start), .mcand(mreq.mcand),
      .mplier(mreq.mplier), .done(mdone), .product(mprod));

   logic        ddone;
   logic [63:0] dquo;
   logic [30:0] dden;
   assign dden = (batt_ff != '0) ? 31'(BattDenK * 31'(batt_ff)) : NoBattDen;
   wspc_div u_div (.clock, .reset, .start(start_div_ff), .dividend(mag_ff),
      .divisor(dden), .done(ddone), .quotient(dquo));

   logic signed [SpdW-1:0] ctgt;
   logic signed [SpdW:0]   ms;
   logic signed [ErrW-1:0] err_c;
   logic signed [IntW:0]   isum;
   logic signed [IntW-1:0] isat;
   logic signed [AccW+1:0] psat;
   logic signed [AccW+1:0] vfloor;
   logic signed [VoltW-1:0] vclamp;
   logic signed [AccW:0]   sfloor;
   logic signed [17:0]     mvs;
   logic                   accept;
   logic                   deliver;

   assign ms = {1'b0, maxspd_ff};
   assign ctgt = ($signed({tgt_ff[SpdW-1], tgt_ff}) > ms) ? SpdW'(ms) :
                 ($signed({tgt_ff[SpdW-1], tgt_ff}) < -ms) ? SpdW'(-ms) : tgt_ff;
   assign err_c = ErrW'(ctgt) - ErrW'(speed_ff);
   assign isum = (IntW+1)'(integ_ff) + (IntW+1)'(err_c);
   assign isat = (isum[IntW] != isum[IntW-1]) ?
                 {isum[IntW], {(IntW-1){~isum[IntW]}}} : isum[IntW-1:0];
   // Saturate product magnitude at 2^62
   always_comb begin
      psat = (AccW+2)'(mprod);
      if (mprod > $signed((AccW+1)'(1) <<< 62)) psat = (AccW+2)'(1) <<< 62;
      else if (mprod < -$signed((AccW+1)'(1) <<< 62)) psat = -((AccW+2)'(1) <<< 62);
   end
   assign sfloor = mprod >>> 16;
   assign vfloor = acc_ff >>> 16;
   assign mvs = {2'b00, maxv_ff};
   assign vclamp = (vfloor > (AccW+2)'(mvs)) ? VoltW'(mvs) :
                   (vfloor < -(AccW+2)'(mvs)) ? VoltW'(-mvs) : VoltW'(vfloor);

   assign accept = req.valid && req.ready;
   assign deliver = rsp.valid && rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && (!ovalid_ff || rsp.ready);

   // Sequencer: next state and multiplier starts
   always_comb begin
      state_in = state_ff;
      mreq = '{start: 1'b0, mcand: '0, mplier: '0};
      unique case (state_ff)
         ST_IDLE: if (accept) begin
            state_in = ST_SCALE;
            mreq = '{start: 1'b1, mcand: sscale_ff, mplier: (IntW+1)'(req.encoder_count)};
         end
         ST_SCALE: if (mdone) begin
            state_in = ST_SPEED;
            mreq = '{start: 1'b1, mcand: dscale_ff, mplier: (IntW+1)'(cnt_ff)};
         end
         ST_SPEED: if (mdone) begin
            if (en_ff) begin
               state_in = ST_PID_P;
               mreq = '{start: 1'b1, mcand: kp_ff, mplier: (IntW+1)'(err_c)};
            end else begin
               state_in = ST_DUTY_MUL;
            end
         end
         ST_PID_P: if (mdone) begin
            state_in = ST_PID_I;
            mreq = '{start: 1'b1, mcand: ki_ff, mplier: (IntW+1)'(integ_ff)};
         end
         ST_PID_I: if (mdone) begin
            state_in = ST_PID_D;
            mreq = '{start: 1'b1, mcand: kd_ff, mplier: (IntW+1)'(deriv_ff)};
         end
         ST_PID_D: if (mdone) state_in = ST_VOLT;
         ST_VOLT: state_in = ST_DUTY_MUL;
         ST_DUTY_MUL: begin
            state_in = ST_DUTY_DIV;
            mreq = '{start: 1'b1,
                     mcand: (batt_ff != '0) ? GainW'(BattNumK >> 7) : GainW'(NoBattNumK),
                     mplier: (IntW+1)'(hold_ff)};
         end
         ST_DUTY_DIV: if (mdone) state_in = ST_DONE;
         ST_DONE: if (ddone) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Duty numerator for the battery case is K = (K>>7)*128 + (K&127):
   // the low part is added after the serial product.
   logic [6:0] klow;
   assign klow = BattNumK[6:0];
   logic signed [AccW+1:0] numfull;
   assign numfull = (batt_ff != '0) ?
      (((AccW+2)'(mprod) <<< 7) + (AccW+2)'(hold_ff) * (AccW+2)'(klow)) :
      (AccW+2)'(mprod);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ovalid_ff <= 1'b0;
         integ_ff <= '0; perr_ff <= '0; pos_ff <= '0; hold_ff <= '0;
         start_div_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_div_ff <= state_ff == ST_DUTY_DIV && mdone;
         if (deliver) ovalid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (accept) begin
               cnt_ff <= req.encoder_count; batt_ff <= req.battery_reading;
               tgt_ff <= req.target_speed; clr_ff <= req.clear_position;
            end
            ST_SCALE: if (mdone) begin
               if (sfloor > (AccW+1)'(1048575)) speed_ff <= SpdW'(1048575);
               else if (sfloor < -(AccW+1)'(1048576)) speed_ff <= SpdW'(-1048576);
               else speed_ff <= SpdW'(sfloor);
            end
            ST_SPEED: if (mdone) begin
               pos_ff <= (clr_ff ? '0 : pos_ff) + PosW'(sfloor);
               if (en_ff) begin
                  deriv_ff <= (ErrW+1)'(err_c) - (ErrW+1)'(perr_ff);
                  perr_ff <= err_c;
                  integ_ff <= isat;
               end
            end
            ST_PID_P: if (mdone) acc_ff <= psat;
            ST_PID_I: if (mdone) acc_ff <= acc_ff + psat;
            ST_PID_D: if (mdone) acc_ff <= acc_ff + psat;
            ST_VOLT: begin
               if (ctgt == '0 && speed_ff == '0) begin
                  integ_ff <= '0; hold_ff <= '0;
               end else begin
                  hold_ff <= vclamp;
               end
            end
            ST_DUTY_DIV: if (mdone) begin
               neg_ff <= numfull < 0;
               mag_ff <= (numfull < 0) ? 64'(-numfull) : 64'(numfull);
            end
            ST_DONE: if (ddone) begin
               duty_ff <= (dquo > 64'd65535) ? 16'hFFFF : dquo[15:0];
               dir_ff <= (dquo == '0) ? DirBrake : (neg_ff ? DirReverse : DirForward);
               ovolt_ff <= hold_ff; ospd_ff <= speed_ff; opos_ff <= pos_ff;
               ovalid_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign rsp.valid = ovalid_ff;
   assign rsp.duty = duty_ff;
   assign rsp.direction = dir_ff;
   assign rsp.drive_voltage = ovolt_ff;
   assign rsp.measured_speed = ospd_ff;
   assign rsp.travelled_distance = opos_ff;

   a_busy_block: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req.ready) else $error("ready while busy");
   a_volt_range: assert property (@(posedge clock) disable iff (reset)
      ovalid_ff |-> ovolt_ff <= 17'sd65535 && ovolt_ff >= -17'sd65535)
      else $error("voltage out of range");
   a_brake: assert property (@(posedge clock) disable iff (reset)
      ovalid_ff && duty_ff == '0 |-> dir_ff == DirBrake)
      else $error("zero duty with drive");
endmodule
`default_nettype wire
